### rtl/core/mce_pkg.sv
// Morse encoder package: shared constants, queue entry type and code table.
// Used by all modules of the morse_code_encoder block.
`default_nettype none
package mce_pkg;

	localparam logic [7:0] FIRST_CODE = 8'd43;
	localparam logic [7:0] LAST_CODE  = 8'd92;

	localparam int CODE_W     = 7;
	localparam int MAX_UNITS  = 20;
	localparam int UNIT_CNT_W = $clog2(MAX_UNITS);
	localparam int GAP_W      = 2;

	localparam logic [GAP_W-1:0] GAP_MAPPED   = 2'd2;
	localparam logic [GAP_W-1:0] GAP_UNMAPPED = 2'd3;

	localparam int QDEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int QCNT_W = 2;

	localparam logic [CODE_W-1:0] CODE_MARKER = 7'd1;

	typedef struct packed {
		logic              unmapped;
		logic [CODE_W-1:0] code;
	} entry_t;

	typedef struct packed {
		logic   valid;
		entry_t data;
	} qport_t;

	function automatic entry_t code_lookup(input logic [7:0] ch);
		logic [7:0]        idx;
		logic [CODE_W-1:0] c;
		entry_t            e;
		idx = ch - FIRST_CODE;
		unique case (idx)
			8'd0:  c = 7'h35;
			8'd1:  c = 7'h4C;
			8'd2:  c = 7'h5E;
			8'd3:  c = 7'h55;
			8'd4:  c = 7'h36;
			8'd5:  c = 7'h20;
			8'd6:  c = 7'h21;
			8'd7:  c = 7'h23;
			8'd8:  c = 7'h27;
			8'd9:  c = 7'h2F;
			8'd10: c = 7'h3F;
			8'd11: c = 7'h3E;
			8'd12: c = 7'h3C;
			8'd13: c = 7'h38;
			8'd14: c = 7'h30;
			8'd15: c = 7'h02;
			8'd16: c = 7'h02;
			8'd17: c = 7'h02;
			8'd18: c = 7'h2E;
			8'd19: c = 7'h02;
			8'd20: c = 7'h73;
			8'd21: c = 7'h69;
			8'd22: c = 7'h05;
			8'd23: c = 7'h1E;
			8'd24: c = 7'h1A;
			8'd25: c = 7'h0E;
			8'd26: c = 7'h03;
			8'd27: c = 7'h1B;
			8'd28: c = 7'h0C;
			8'd29: c = 7'h1F;
			8'd30: c = 7'h07;
			8'd31: c = 7'h11;
			8'd32: c = 7'h0A;
			8'd33: c = 7'h1D;
			8'd34: c = 7'h04;
			8'd35: c = 7'h06;
			8'd36: c = 7'h08;
			8'd37: c = 7'h19;
			8'd38: c = 7'h14;
			8'd39: c = 7'h0D;
			8'd40: c = 7'h0F;
			8'd41: c = 7'h02;
			8'd42: c = 7'h0B;
			8'd43: c = 7'h17;
			8'd44: c = 7'h09;
			8'd45: c = 7'h16;
			8'd46: c = 7'h12;
			8'd47: c = 7'h1C;
			8'd48: c = 7'h2A;
			8'd49: c = 7'h57;
			default: c = CODE_MARKER;
		endcase
		e.unmapped = (ch < FIRST_CODE) || (ch > LAST_CODE);
		e.code     = e.unmapped ? CODE_MARKER : c;
		return e;
	endfunction

endpackage
`default_nettype wire

### rtl/core/mce_if.sv
// Handshake channel interfaces for the Morse encoder: characters in, key units out.
// Depends on nothing.
`default_nettype none
interface mce_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	modport source (output valid, output char_code, input ready);
	modport sink   (input valid, input char_code, output ready);
endinterface

interface mce_unit_if;
	logic valid;
	logic ready;
	logic key_on;
	logic last_unit;
	modport source (output valid, output key_on, output last_unit, input ready);
	modport sink   (input valid, input key_on, input last_unit, output ready);
endinterface
`default_nettype wire

### rtl/core/mce_front.sv
// Front end: accepts characters, classifies them and looks up their Morse code.
// Depends on mce_pkg and mce_char_if.
`default_nettype none
module mce_front (
	mce_char_if.sink         chars,
	input  logic             q_full,
	output mce_pkg::qport_t  push
);

	assign chars.ready = !q_full;
	assign push.valid  = chars.valid && !q_full;
	assign push.data   = mce_pkg::code_lookup(chars.char_code);

endmodule
`default_nettype wire

### rtl/core/mce_fifo.sv
// Two-entry queue between front and back end of the Morse encoder.
// Depends on mce_pkg.
`default_nettype none
module mce_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  mce_pkg::qport_t  push,
	output logic             full,
	output mce_pkg::qport_t  head,
	input  logic             pop
);

	mce_pkg::entry_t                 mem_q [mce_pkg::QDEPTH];
	logic [mce_pkg::QPTR_W-1:0]      wr_ptr_q;
	logic [mce_pkg::QPTR_W-1:0]      rd_ptr_q;
	logic [mce_pkg::QCNT_W-1:0]      count_q;
	logic                            do_push;
	logic                            do_pop;

	assign full       = (count_q == mce_pkg::QCNT_W'(mce_pkg::QDEPTH));
	assign head.valid = (count_q != '0);
	assign head.data  = mem_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head.valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= mce_pkg::QCNT_W'(mce_pkg::QDEPTH))
		else $error("queue count overflow");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0 || full) |-> (wr_ptr_q == rd_ptr_q))
		else $error("queue pointers out of step with count");

endmodule
`default_nettype wire

### rtl/core/mce_back.sv
// Back end: expands one queued code into dit/dah key units plus the letter gap.
// Depends on mce_pkg and mce_unit_if.
`default_nettype none
module mce_back (
	input  logic                clk,
	input  logic                arst_n,
	input  mce_pkg::qport_t     head,
	output logic                pop,
	mce_unit_if.source          units
);

	logic                              busy_q;
	logic [mce_pkg::CODE_W-1:0]        val_q;
	logic [1:0]                        pos_q;
	logic [mce_pkg::GAP_W-1:0]         gap_q;
	logic [mce_pkg::UNIT_CNT_W-1:0]    cnt_q;
	logic                              ovalid_q;
	logic                              key_q;
	logic                              last_q;

	logic in_elem;
	logic dit;
	logic key;
	logic elem_end;
	logic last;
	logic step;

	always_comb begin
		in_elem  = (val_q > mce_pkg::CODE_MARKER);
		dit      = val_q[0];
		key      = in_elem && (dit ? (pos_q == 2'd0) : (pos_q != 2'd3));
		elem_end = dit ? (pos_q == 2'd1) : (pos_q == 2'd3);
		last     = (!in_elem && gap_q == mce_pkg::GAP_W'(1))
		        || (cnt_q == mce_pkg::UNIT_CNT_W'(mce_pkg::MAX_UNITS - 1));
		step     = busy_q && (!ovalid_q || units.ready);
		pop      = head.valid && (!busy_q || (step && last));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			val_q  <= mce_pkg::CODE_MARKER;
			pos_q  <= '0;
			gap_q  <= '0;
			cnt_q  <= '0;
		end else if (pop) begin
			busy_q <= 1'b1;
			val_q  <= head.data.code;
			pos_q  <= '0;
			gap_q  <= head.data.unmapped ? mce_pkg::GAP_UNMAPPED : mce_pkg::GAP_MAPPED;
			cnt_q  <= '0;
		end else if (step) begin
			if (last) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q + 1'b1;
			if (in_elem) begin
				if (elem_end) begin
					val_q <= val_q >> 1;
					pos_q <= '0;
				end else begin
					pos_q <= pos_q + 1'b1;
				end
			end else begin
				gap_q <= gap_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovalid_q <= 1'b0;
		end else if (step) begin
			ovalid_q <= 1'b1;
		end else if (units.ready) begin
			ovalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			key_q  <= key;
			last_q <= last;
		end
	end

	assign units.valid     = ovalid_q;
	assign units.key_on    = key_q;
	assign units.last_unit = last_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q < mce_pkg::UNIT_CNT_W'(mce_pkg::MAX_UNITS)))
		else $error("unit count past limit");

	a_dah_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && pos_q >= 2'd2) |-> (in_elem && !dit))
		else $error("dit element ran past two units");

	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(step && last && !pop) |=> !busy_q)
		else $error("engine kept running after final unit");

	a_load_fresh: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> (busy_q && cnt_q == '0 && pos_q == 2'd0))
		else $error("new character not loaded cleanly");

endmodule
`default_nettype wire

### rtl/core/morse_code_encoder.sv
// Morse code encoder top level: front end, two-entry queue and key-unit back end.
// Depends on mce_pkg, mce_if, mce_front, mce_fifo and mce_back.
//
// Usage:
//   chars: one 8-bit ASCII character per transfer (valid/ready).
//   units: one key unit per transfer; key_on is tone on/off for one dit time,
//          last_unit flags the final unit of a character.
//   '+' through backslash are keyed from a fixed code table: a dit is 1,0, a
//   dah is 1,1,1,0, followed by 0,0 as letter gap. At most 20 units are sent
//   per character, so the gap of '0' and ',' is cut short. All other bytes,
//   lowercase included, give 0,0,0.
//   Throughput: one unit per cycle while the receiver is ready, set by the
//   single back-end expansion engine; a character gives 3 to 20 units. The
//   two-entry queue lets the front accept up to two more characters while
//   one is being keyed. Reset clears the queue, the engine and the output
//   register; no character is pending afterward. When the receiver stalls,
//   the output unit holds and the engine waits; characters are taken until
//   the queue is full.
`default_nettype none
module morse_code_encoder (
	input  logic        clk,
	input  logic        arst_n,
	mce_char_if.sink    chars,
	mce_unit_if.source  units
);

	mce_pkg::qport_t push;
	mce_pkg::qport_t head;
	logic            q_full;
	logic            pop;

	mce_front u_front (
		.chars  (chars),
		.q_full (q_full),
		.push   (push)
	);

	mce_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (q_full),
		.head   (head),
		.pop    (pop)
	);

	mce_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.pop    (pop),
		.units  (units)
	);

endmodule
`default_nettype wire

### test/mce_checker.sv
// Checker for morse_code_encoder: watches the character and key-unit channels,
// predicts the key units of each character and compares them in order.
// Depends on mce_pkg (code range, unit limit) and mce_if.
module mce_checker (
	input  logic  clk,
	input  logic  arst_n,
	mce_char_if   chars,
	mce_unit_if   units,
	output int    fail_count,
	output int    pending_units,
	output int    units_seen
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic key_on;
		logic last_unit;
	} key_unit_t;

	// LSB first, 1 = dit, 0 = dah, leading 1 is the end marker
	logic [6:0] morse_table [0:49];
	key_unit_t  expected_units [$];
	key_unit_t  want;

	initial begin
		fail_count = 0;
		morse_table = '{
			7'h35, 7'h4C, 7'h5E, 7'h55, 7'h36,
			7'h20, 7'h21, 7'h23, 7'h27, 7'h2F,
			7'h3F, 7'h3E, 7'h3C, 7'h38, 7'h30,
			7'h02, 7'h02, 7'h02, 7'h2E, 7'h02, 7'h73, 7'h69,
			7'h05, 7'h1E, 7'h1A, 7'h0E, 7'h03, 7'h1B, 7'h0C, 7'h1F,
			7'h07, 7'h11, 7'h0A, 7'h1D, 7'h04, 7'h06, 7'h08, 7'h19,
			7'h14, 7'h0D, 7'h0F, 7'h02, 7'h0B, 7'h17, 7'h09, 7'h16,
			7'h12, 7'h1C,
			7'h2A, 7'h57
		};
	end

	function automatic void key_character(input logic [7:0] ch);
		logic [6:0] pattern;
		bit         tones [$];
		key_unit_t  u;
		int         n;
		if (ch < mce_pkg::FIRST_CODE || ch > mce_pkg::LAST_CODE) begin
			repeat (3) tones.push_back(1'b0);
		end else begin
			pattern = morse_table[ch - mce_pkg::FIRST_CODE];
			while (pattern > 7'd1) begin
				if (pattern[0]) begin
					tones.push_back(1'b1);
				end else begin
					repeat (3) tones.push_back(1'b1);
				end
				tones.push_back(1'b0);
				pattern = pattern >> 1;
			end
			repeat (2) tones.push_back(1'b0);
		end
		// long codes lose the tail of their letter gap
		n = (tones.size() > mce_pkg::MAX_UNITS) ? mce_pkg::MAX_UNITS : tones.size();
		for (int k = 0; k < n; k++) begin
			u.key_on    = tones[k];
			u.last_unit = (k == n - 1);
			expected_units.push_back(u);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_units.delete();
			pending_units <= 0;
			units_seen    <= 0;
		end else begin
			if (units.valid && units.ready) begin
				if (expected_units.size() == 0) begin
					$error("unexpected key unit: key_on=%0b last_unit=%0b",
						units.key_on, units.last_unit);
					fail_count++;
				end else begin
					want = expected_units.pop_front();
					if (units.key_on !== want.key_on) begin
						$error("key_on: expected %0b, got %0b", want.key_on, units.key_on);
						fail_count++;
					end
					if (units.last_unit !== want.last_unit) begin
						$error("last_unit: expected %0b, got %0b",
							want.last_unit, units.last_unit);
						fail_count++;
					end
				end
				units_seen <= units_seen + 1;
			end
			if (chars.valid && chars.ready) begin
				key_character(chars.char_code);
			end
			pending_units <= expected_units.size();
		end
	end
endmodule

### test/tb.sv
// Testbench top for morse_code_encoder: clock, reset, character stimulus and
// receiver stalls; mce_checker does the prediction and comparison.
// Depends on mce_pkg, mce_if, morse_code_encoder and mce_checker.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_CHARS = 147;
	localparam int LONG_HOLD    = 150;
	localparam int CYCLE_LIMIT  = 200000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending_units;
	int   units_seen;
	int   cycle_count = 0;
	int   chars_sent = 0;
	int   burst_left = 0;
	int   holds_requested = 0;
	int   holds_done = 0;

	logic [7:0] directed_chars [$] = '{
		8'h2B, 8'h2C, 8'h2D, 8'h2E, 8'h2F, 8'h30, 8'h39, 8'h3A,
		8'h3F, 8'h40, 8'h41, 8'h45, 8'h54, 8'h5A, 8'h5B, 8'h5C,
		8'h00, 8'h2A, 8'h5D, 8'h61, 8'h7F, 8'h80, 8'hFF
	};

	mce_char_if chars ();
	mce_unit_if units ();

	morse_code_encoder dut (
		.clk    (clk),
		.arst_n (arst_n),
		.chars  (chars.sink),
		.units  (units.source)
	);

	mce_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.chars         (chars),
		.units         (units),
		.fail_count    (fail_count),
		.pending_units (pending_units),
		.units_seen    (units_seen)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("** morse_code_encoder: FAILED **");
			$finish;
		end
	end

	task automatic send_char(input logic [7:0] ch);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
			burst_left = $urandom_range(1, 12);
			if (gap > 0) begin
				chars.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		chars.valid     <= 1'b1;
		chars.char_code <= ch;
		@(posedge clk);
		while (!chars.ready) @(posedge clk);
		chars_sent++;
	endtask

	// receiver: requested long holds, else segments of free flow, random stalls or a fixed pattern
	initial begin
		int seg_len;
		int mode;
		int k;
		units.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (holds_done < holds_requested) begin
				units.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				holds_done++;
			end else begin
				mode    = $urandom_range(0, 3);
				seg_len = $urandom_range(4, 40);
				for (k = 0; k < seg_len; k++) begin
					case (mode)
						0: units.ready <= 1'b1;
						1: units.ready <= ($urandom_range(0, 3) != 0);
						2: units.ready <= (k % 5 != 4);
						default: units.ready <= ($urandom_range(0, 3) == 0);
					endcase
					@(posedge clk);
				end
			end
		end
	end

	initial begin
		int n;
		logic [7:0] ch;
		arst_n          = 1'b0;
		chars.valid     = 1'b0;
		chars.char_code = 8'h00;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_chars[i]) send_char(directed_chars[i]);

		for (n = 0; n < RANDOM_CHARS; n++) begin
			if (n == 0 || n == 100) holds_requested++;
			case ($urandom_range(0, 19))
				0, 1:    ch = $urandom_range(8'h61, 8'h7A);
				2, 3, 4: ch = $urandom_range(0, 255);
				default: ch = $urandom_range(8'h2B, 8'h5C);
			endcase
			send_char(ch);
		end
		chars.valid <= 1'b0;
		@(posedge clk);
		while (pending_units != 0) @(posedge clk);
		repeat (10) @(posedge clk);

		$display("Keyed %0d characters (%0d directed) into %0d checked key units,",
			chars_sent, directed_chars.size(), units_seen);
		$display("with %0d long receiver hold-offs and random gaps on both sides.",
			holds_done);
		if (fail_count == 0) begin
			$display("** morse_code_encoder: PASSED **");
		end else begin
			$display("** morse_code_encoder: FAILED **");
		end
		$finish;
	end
endmodule
